FILE: design/sbt_pkg.sv
// ----------------------------------------------------------------------------
// sbt_pkg: shared types and constants of the sorted bin table
// Table geometry, payload structs, status codes and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package sbt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int PTR_W       = $clog2(TABLE_DEPTH + 1);
	localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(TABLE_DEPTH);

	localparam int DIV_W     = 48;
	localparam int DSR_W     = 16;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHALLOW  = 2'd1;

	localparam logic [2:0] ST_EXIST   = 3'd0;
	localparam logic [2:0] ST_NEW     = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_SHALLOW = 3'd3;
	localparam logic [2:0] ST_HIT     = 3'd4;
	localparam logic [2:0] ST_EMPTY   = 3'd5;

	typedef struct packed {
		logic        mode;
		logic [31:0] record_value;
		logic [30:0] range_begin;
		logic [30:0] range_end;
		logic [15:0] index_points;
		logic [15:0] scale_count;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  slot;
		logic [31:0] bin_number;
		logic [31:0] relative_index;
		logic [39:0] record_total;
		logic        last;
	} out_item_t;

	typedef enum logic [1:0] {
		DS_VALUE,
		DS_BEGIN,
		DS_END,
		DS_SCALE
	} div_sel_t;

	typedef enum logic [2:0] {
		OK_SHALLOW,
		OK_EXIST,
		OK_NEW,
		OK_FULL,
		OK_PEND_MORE,
		OK_PEND_LAST,
		OK_EMPTY
	} out_kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DSTART,
		S_DWAIT_A,
		S_DWAIT_B,
		S_OSH,
		S_RD,
		S_CMP,
		S_FLUSH,
		S_MUL,
		S_SCL,
		S_SWAIT,
		S_QEND,
		S_OEX,
		S_INS,
		S_INS2,
		S_ONEW
	} state_t;

	typedef struct packed {
		logic      take_in;
		logic      cnt_rec;
		logic      div_go;
		div_sel_t  div_sel;
		logic      ld_a;
		logic      ld_b;
		logic      walk_init;
		logic      advance;
		logic      ins_new;
		logic      ins_link;
		logic      used_inc;
		logic      mul;
		logic      pend_set;
		logic      pend_quo;
		logic      out_load;
		out_kind_t out_kind;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic shallow;
		logic div_done;
		logic cur_nil;
		logic ge_key;
		logic eq_key;
		logic ge_t0;
		logic full;
		logic pend;
		logic scale_en;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

FILE: design/sbt_div.sv
// ----------------------------------------------------------------------------
// sbt_div: iterative restoring divider
// One quotient bit per cycle; done is high for a single cycle, together with the finished quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      go,
	input  wire logic [sbt_pkg::DIV_W-1:0] dividend,
	input  wire logic [sbt_pkg::DSR_W-1:0] divisor,
	output logic                           done,
	output logic [sbt_pkg::DIV_W-1:0]      quotient
);
	import sbt_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DSR_W-1:0]     rem_q;
	logic [DSR_W-1:0]     dsr_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DSR_W:0]       trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_LAST);
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DSR_W'(trial - {1'b0, dsr_q}) : trial[DSR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: design/sbt_dp.sv
// ----------------------------------------------------------------------------
// sbt_dp: datapath of the sorted bin table
// Slot memories, list pointers, counters, divider, scaling and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire sbt_pkg::cmd_t                       cmd,
	output sbt_pkg::sts_t                            sts,
	input  wire sbt_pkg::in_item_t                   in_data,
	input  wire logic                                cfg_valid,
	input  wire logic [sbt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sbt_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output sbt_pkg::out_item_t                       out_data
);
	import sbt_pkg::*;

	logic [31:0]       slot_bin  [TABLE_DEPTH];
	logic [PTR_W-1:0]  slot_link [TABLE_DEPTH];

	logic [12:0]       bin_size_q;
	logic              shallow_q;
	in_item_t          in_q;
	logic [31:0]       a_q;
	logic [31:0]       t1_q;
	logic [PTR_W-1:0]  cur_q;
	logic [PTR_W-1:0]  prev_q;
	logic [PTR_W-1:0]  first_q;
	logic [PTR_W-1:0]  used_q;
	logic [39:0]       recs_q;
	logic [31:0]       rd_bin_q;
	logic [PTR_W-1:0]  rd_link_q;
	logic [31:0]       rel_q;
	logic [DIV_W-1:0]  prod_q;
	logic              pend_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic [31:0]       pend_bin_q;
	logic [31:0]       pend_rel_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [DIV_W-1:0]  div_dividend;
	logic [DSR_W-1:0]  div_divisor;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;
	logic [31:0]       quo32;
	logic [31:0]       key;
	logic [31:0]       diff;
	logic              out_free;

	assign quo32 = div_quo[31:0];
	assign key   = in_q.mode ? t1_q : a_q;
	assign diff  = rd_bin_q - a_q;

	always_comb begin
		unique case (cmd.div_sel)
			DS_VALUE: div_dividend = DIV_W'(in_q.record_value);
			DS_BEGIN: div_dividend = DIV_W'(in_q.range_begin);
			DS_END:   div_dividend = DIV_W'(in_q.range_end);
			DS_SCALE: div_dividend = prod_q;
			default:  div_dividend = prod_q;
		endcase
		if (cmd.div_sel == DS_SCALE)
			div_divisor = in_q.scale_count;
		else if (bin_size_q == '0)
			div_divisor = DSR_W'(1);
		else
			div_divisor = DSR_W'(bin_size_q);
	end

	sbt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Memories: one synchronous read at the current pointer, one write port each.
	always_ff @(posedge clk) begin
		rd_bin_q  <= slot_bin[cur_q[SLOT_W-1:0]];
		rd_link_q <= slot_link[cur_q[SLOT_W-1:0]];
		if (cmd.ins_new) begin
			slot_bin[used_q[SLOT_W-1:0]]  <= a_q;
			slot_link[used_q[SLOT_W-1:0]] <= cur_q;
		end else if (cmd.ins_link && prev_q != NIL_PTR) begin
			slot_link[prev_q[SLOT_W-1:0]] <= used_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_size_q <= 13'd1;
			shallow_q  <= 1'b0;
			first_q    <= NIL_PTR;
			used_q     <= '0;
			recs_q     <= '0;
			pend_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_BIN_SIZE)
					bin_size_q <= cfg_data;
				else if (cfg_index == CFG_SHALLOW)
					shallow_q <= cfg_data[0];
			end
			if (cmd.cnt_rec)
				recs_q <= recs_q + 40'd1;
			if (cmd.ins_link && prev_q == NIL_PTR)
				first_q <= used_q;
			if (cmd.used_inc)
				used_q <= used_q + 1'b1;
			if (cmd.pend_set)
				pend_q <= 1'b1;
			else if (cmd.out_load &&
				(cmd.out_kind == OK_PEND_MORE || cmd.out_kind == OK_PEND_LAST))
				pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in)
			in_q <= in_data;
		if (cmd.ld_a)
			a_q <= quo32;
		if (cmd.ld_b)
			t1_q <= (quo32 == a_q) ? quo32 + 32'd1 : quo32;
		if (cmd.walk_init) begin
			cur_q  <= first_q;
			prev_q <= NIL_PTR;
		end else if (cmd.advance) begin
			prev_q <= cur_q;
			cur_q  <= rd_link_q;
		end
		if (cmd.mul) begin
			rel_q  <= diff;
			prod_q <= {16'd0, diff} * {32'd0, in_q.index_points};
		end
		if (cmd.pend_set) begin
			pend_slot_q <= cur_q[SLOT_W-1:0];
			pend_bin_q  <= rd_bin_q;
			pend_rel_q  <= cmd.pend_quo ? quo32 : rel_q;
		end
	end

	// Result register: a new result may be loaded in the cycle the old one leaves.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.record_total   <= recs_q;
			out_q.relative_index <= '0;
			out_q.last           <= 1'b1;
			out_q.slot           <= '0;
			out_q.bin_number     <= a_q;
			unique case (cmd.out_kind)
				OK_SHALLOW: begin
					out_q.status     <= ST_SHALLOW;
					out_q.bin_number <= '0;
				end
				OK_EXIST: begin
					out_q.status <= ST_EXIST;
					out_q.slot   <= 6'(cur_q[SLOT_W-1:0]);
				end
				OK_NEW: begin
					out_q.status <= ST_NEW;
					out_q.slot   <= 6'(used_q[SLOT_W-1:0]);
				end
				OK_FULL: begin
					out_q.status <= ST_FULL;
				end
				OK_PEND_MORE, OK_PEND_LAST: begin
					out_q.status         <= ST_HIT;
					out_q.slot           <= 6'(pend_slot_q);
					out_q.bin_number     <= pend_bin_q;
					out_q.relative_index <= pend_rel_q;
					out_q.last           <= (cmd.out_kind == OK_PEND_LAST);
				end
				OK_EMPTY: begin
					out_q.status     <= ST_EMPTY;
					out_q.bin_number <= '0;
				end
				default: begin
					out_q.status <= ST_EMPTY;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		sts.mode     = in_q.mode;
		sts.shallow  = shallow_q;
		sts.div_done = div_done;
		sts.cur_nil  = (cur_q == NIL_PTR);
		sts.ge_key   = rd_bin_q >= key;
		sts.eq_key   = rd_bin_q == key;
		sts.ge_t0    = rd_bin_q >= a_q;
		sts.full     = used_q >= NIL_PTR;
		sts.pend     = pend_q;
		sts.scale_en = (in_q.index_points != '0) && (in_q.index_points < in_q.scale_count);
		sts.out_free = out_free;
	end

endmodule

`default_nettype wire

FILE: design/sbt_ctrl.sv
// ----------------------------------------------------------------------------
// sbt_ctrl: controller of the sorted bin table
// Sequences division, list walk, insertion and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire sbt_pkg::sts_t  sts,
	output sbt_pkg::cmd_t       cmd
);
	import sbt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.div_sel  = DS_VALUE;
		cmd.out_kind = OK_EMPTY;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d     = S_DSTART;
				end
			end
			S_DSTART: begin
				if (!sts.mode) begin
					cmd.cnt_rec = 1'b1;
					if (sts.shallow) begin
						state_d = S_OSH;
					end else begin
						cmd.div_go = 1'b1;
						state_d    = S_DWAIT_A;
					end
				end else begin
					cmd.div_go  = 1'b1;
					cmd.div_sel = DS_BEGIN;
					state_d     = S_DWAIT_A;
				end
			end
			S_DWAIT_A: begin
				if (sts.div_done) begin
					cmd.ld_a = 1'b1;
					if (sts.mode) begin
						cmd.div_go  = 1'b1;
						cmd.div_sel = DS_END;
						state_d     = S_DWAIT_B;
					end else begin
						cmd.walk_init = 1'b1;
						state_d       = S_RD;
					end
				end
			end
			S_DWAIT_B: begin
				if (sts.div_done) begin
					cmd.ld_b      = 1'b1;
					cmd.walk_init = 1'b1;
					state_d       = S_RD;
				end
			end
			S_OSH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OK_SHALLOW;
					state_d      = S_IDLE;
				end
			end
			S_RD: begin
				if (sts.cur_nil)
					state_d = sts.mode ? S_QEND : S_INS;
				else
					state_d = S_CMP;
			end
			S_CMP: begin
				if (!sts.mode) begin
					if (sts.ge_key) begin
						state_d = sts.eq_key ? S_OEX : S_INS;
					end else begin
						cmd.advance = 1'b1;
						state_d     = S_RD;
					end
				end else if (sts.ge_key) begin
					state_d = S_QEND;
				end else if (sts.ge_t0) begin
					state_d = sts.pend ? S_FLUSH : S_MUL;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_RD;
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OK_PEND_MORE;
					state_d      = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SCL;
			end
			S_SCL: begin
				cmd.div_sel = DS_SCALE;
				if (sts.scale_en) begin
					cmd.div_go = 1'b1;
					state_d    = S_SWAIT;
				end else begin
					cmd.pend_set = 1'b1;
					cmd.advance  = 1'b1;
					state_d      = S_RD;
				end
			end
			S_SWAIT: begin
				cmd.div_sel = DS_SCALE;
				if (sts.div_done) begin
					cmd.pend_set = 1'b1;
					cmd.pend_quo = 1'b1;
					cmd.advance  = 1'b1;
					state_d      = S_RD;
				end
			end
			S_QEND: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = sts.pend ? OK_PEND_LAST : OK_EMPTY;
					state_d      = S_IDLE;
				end
			end
			S_OEX: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OK_EXIST;
					state_d      = S_IDLE;
				end
			end
			S_INS: begin
				if (sts.full) begin
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_kind = OK_FULL;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.ins_new = 1'b1;
					state_d     = S_INS2;
				end
			end
			S_INS2: begin
				cmd.ins_link = 1'b1;
				state_d      = S_ONEW;
			end
			S_ONEW: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OK_NEW;
					cmd.used_inc = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: design/sorted_bin_table_with_range_query_top.sv
// ----------------------------------------------------------------------------
// sorted_bin_table_with_range_query_top: sorted histogram bin table
// Inserts record values as bins into an ordered table and answers range queries.
// ----------------------------------------------------------------------------
// Usage:
// An item enters on in_valid/in_ready; in_ready is high only while the block is
// idle, and one item is worked at a time. Mode 0 inserts a record and gives one
// result; mode 1 is a range query that gives one result per stored bin in the
// range, in ascending order, or a single empty result, the final one marked last.
// Every division (bin number, range bounds, index scaling) runs on one shared
// bit-serial divider of 48 steps. The list walk reads each visited slot in
// S_RD and compares it in S_CMP, as the slot memory is read synchronously.
// Results leave through an output register; while the receiver stalls, the walk
// holds at its next result and no further item is taken. The configuration
// channel is always ready and unguarded; write it only while the block is idle.
// Reset empties the table, clears the record count and sets bin size 1; the slot
// memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_bin_table_with_range_query_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire sbt_pkg::in_item_t                   in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output sbt_pkg::out_item_t                       out_data,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [sbt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sbt_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import sbt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	sbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sbt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

FILE: design/sbt_checker.sv
// ----------------------------------------------------------------------------
// sbt_checker: port-level checks of the sorted bin table
// Watches the result channel and the request handshake of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire sbt_pkg::out_item_t out_data
);
	import sbt_pkg::*;

	// A stalled result must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Insert results are always single and final.
	a_insert_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_EXIST || out_data.status == ST_NEW ||
		out_data.status == ST_FULL || out_data.status == ST_SHALLOW) |-> out_data.last)
		else $error("insert result not marked last");

	// An empty range gives a blank final result.
	a_empty_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_EMPTY |->
		out_data.last && out_data.slot == '0 && out_data.relative_index == '0)
		else $error("malformed empty range result");

	// A request just taken cannot be followed at once by another one.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

endmodule

bind sorted_bin_table_with_range_query_top sbt_checker u_sbt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

FILE: tb/tb_sorted_bin_table_with_range_query_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_bin_table_with_range_query_top: self-checking bench of the bin table
// A directed table of requests, then random phases under several bin sizes and
// shallow mode, all scored in order against a behavioural model of the table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_bin_table_with_range_query_top;
	import sbt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int IDLE_PCT = 7;

	typedef struct {
		in_item_t  req;
		bit        typed;
		out_item_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Model state of the table.
	logic [31:0] bin_of_slot [TABLE_DEPTH];
	logic [6:0]  next_of_slot [TABLE_DEPTH];
	logic [6:0]  head_slot;
	logic [6:0]  slots_taken;
	logic [39:0] records_counted;
	logic [12:0] bin_size_reg;
	logic        shallow_reg;

	out_item_t pending_results [$];
	row_t      request_table [$];
	int errors = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int full_seen = 0;
	int longest_query = 0;
	int idle_cycles = 0;
	bit sender_calm = 1'b0;

	sorted_bin_table_with_range_query_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic out_item_t make_result(logic [2:0] st, logic [5:0] sl,
			logic [31:0] bn, logic [31:0] ri, logic [39:0] tot, logic lst);
		out_item_t r;
		r.status = st;
		r.slot = sl;
		r.bin_number = bn;
		r.relative_index = ri;
		r.record_total = tot;
		r.last = lst;
		return r;
	endfunction

	function automatic in_item_t make_insert(logic [31:0] v);
		in_item_t r;
		r = '0;
		r.record_value = v;
		return r;
	endfunction

	function automatic in_item_t make_query(logic [30:0] b, logic [30:0] e,
			logic [15:0] p, logic [15:0] c);
		in_item_t r;
		r = '0;
		r.mode = 1'b1;
		r.range_begin = b;
		r.range_end = e;
		r.index_points = p;
		r.scale_count = c;
		return r;
	endfunction

	function automatic logic [31:0] divisor_now();
		return (bin_size_reg == 0) ? 32'd1 : {19'd0, bin_size_reg};
	endfunction

	// Works out the results of one accepted request and updates the model table.
	function automatic void predict_request(in_item_t it);
		logic [31:0] key, t0, t1, rel, b;
		logic [6:0] cur, prev, s;
		int hits;
		hits = 0;
		if (!it.mode) begin
			records_counted = records_counted + 40'd1;
			if (shallow_reg) begin
				pending_results.push_back(make_result(ST_SHALLOW, 0, 0, 0,
					records_counted, 1'b1));
				return;
			end
			key = it.record_value / divisor_now();
			prev = NIL_PTR;
			cur = head_slot;
			for (int n = 0; n < TABLE_DEPTH && cur < NIL_PTR; n++) begin
				if (bin_of_slot[cur[5:0]] >= key)
					break;
				prev = cur;
				cur = next_of_slot[cur[5:0]];
			end
			if (cur < NIL_PTR && bin_of_slot[cur[5:0]] == key) begin
				pending_results.push_back(make_result(ST_EXIST, cur[5:0], key, 0,
					records_counted, 1'b1));
			end else if (slots_taken >= TABLE_DEPTH) begin
				pending_results.push_back(make_result(ST_FULL, 0, key, 0,
					records_counted, 1'b1));
			end else begin
				s = slots_taken;
				slots_taken = slots_taken + 7'd1;
				bin_of_slot[s[5:0]] = key;
				next_of_slot[s[5:0]] = cur;
				if (prev < NIL_PTR)
					next_of_slot[prev[5:0]] = s;
				else
					head_slot = s;
				pending_results.push_back(make_result(ST_NEW, s[5:0], key, 0,
					records_counted, 1'b1));
			end
			return;
		end
		t0 = {1'b0, it.range_begin} / divisor_now();
		t1 = {1'b0, it.range_end} / divisor_now();
		if (t0 == t1)
			t1 = t1 + 32'd1;
		cur = head_slot;
		for (int n = 0; n < TABLE_DEPTH && cur < NIL_PTR; n++) begin
			b = bin_of_slot[cur[5:0]];
			if (b >= t1)
				break;
			if (b >= t0) begin
				rel = b - t0;
				if (it.index_points != 0 && it.index_points < it.scale_count)
					rel = 32'((64'(rel) * it.index_points) / it.scale_count);
				pending_results.push_back(make_result(ST_HIT, cur[5:0], b, rel,
					records_counted, 1'b0));
				hits++;
			end
			cur = next_of_slot[cur[5:0]];
		end
		if (hits == 0)
			pending_results.push_back(make_result(ST_EMPTY, 0, 0, 0,
				records_counted, 1'b1));
		else
			pending_results[$].last = 1'b1;
		if (hits > longest_query)
			longest_query = hits;
	endfunction

	task automatic send_request(in_item_t it, bit typed, out_item_t res);
		while (!sender_calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (!in_ready);
		predict_request(it);
		if (typed) begin
			void'(pending_results.pop_back());
			pending_results.push_back(res);
		end
		requests_sent++;
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [12:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_BIN_SIZE)
			bin_size_reg = val;
		else if (idx == CFG_SHALLOW)
			shallow_reg = val[0];
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic in_item_t random_request();
		logic [31:0] d, b;
		logic [15:0] p, c;
		d = divisor_now();
		if ($urandom_range(0, 99) < 60) begin
			if ($urandom_range(0, 99) < 15)
				return make_insert($urandom);
			return make_insert($urandom_range(0, 3000) * d + $urandom_range(0, d - 1));
		end
		p = 0;
		c = 16'($urandom);
		if ($urandom_range(0, 99) < 25) begin
			p = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(1, 40));
			c = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(1, 40));
		end
		if ($urandom_range(0, 99) < 15)
			return make_query(31'($urandom), 31'($urandom), p, c);
		b = $urandom_range(0, 3000) * d;
		return make_query(31'(b), 31'(b + $urandom_range(0, 600) * d
			+ $urandom_range(0, d - 1)), p, c);
	endfunction

	task automatic run_random(int count);
		out_item_t none;
		none = '0;
		for (int i = 0; i < count; i++) begin
			// A stretch with no idling on the request side.
			sender_calm = (i >= count / 3 && i < count / 2);
			send_request(random_request(), 1'b0, none);
		end
		sender_calm = 1'b0;
		drain();
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Result scoring and the watchdog.
	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && out_ready) begin
			results_seen++;
			idle_cycles = 0;
			if (out_data.status == ST_FULL)
				full_seen++;
			if (pending_results.size() == 0) begin
				$error("result arrived with nothing expected: %p", out_data);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, out_data.status);
				check_field("slot", want.slot, out_data.slot);
				check_field("bin_number", want.bin_number, out_data.bin_number);
				check_field("relative_index", want.relative_index,
					out_data.relative_index);
				check_field("record_total", want.record_total, out_data.record_total);
				check_field("last", want.last, out_data.last);
			end
		end else if (in_valid && in_ready) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding",
					pending_results.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Receiver: random stalls, one long hold-off, and a calm stretch.
	initial begin
		int hold;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && results_seen >= 120) begin
				held = 1'b1;
				out_ready <= 1'b0;
				for (hold = 0; hold < 400; hold++)
					@(posedge clk);
			end
			if (results_seen >= 300 && results_seen < 420)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	initial begin
		out_item_t none;
		none = '0;
		head_slot = NIL_PTR;
		slots_taken = '0;
		records_counted = '0;
		bin_size_reg = 13'd1;
		shallow_reg = 1'b0;

		request_table.push_back('{make_query(0, 100, 0, 0), 1,
			make_result(ST_EMPTY, 0, 0, 0, 0, 1)});
		request_table.push_back('{make_insert(0), 1, make_result(ST_NEW, 0, 0, 0, 1, 1)});
		request_table.push_back('{make_insert(32'hFFFF_FFFF), 1,
			make_result(ST_NEW, 1, 32'hFFFF_FFFF, 0, 2, 1)});
		request_table.push_back('{make_insert(0), 1, make_result(ST_EXIST, 0, 0, 0, 3, 1)});
		request_table.push_back('{make_query(0, 0, 0, 0), 1,
			make_result(ST_HIT, 0, 0, 0, 3, 1)});
		request_table.push_back('{make_query(100, 5, 0, 0), 1,
			make_result(ST_EMPTY, 0, 0, 0, 3, 1)});
		request_table.push_back('{make_insert(50), 0, none});
		request_table.push_back('{make_insert(20), 0, none});
		request_table.push_back('{make_insert(35), 0, none});
		request_table.push_back('{make_insert(32'h7FFF_FFFF), 0, none});
		request_table.push_back('{make_query(0, 31'h7FFF_FFFF, 0, 0), 0, none});
		request_table.push_back('{make_query(10, 60, 3, 7), 0, none});
		request_table.push_back('{make_query(0, 60, 16'hFFFF, 16'hFFFE), 0, none});
		request_table.push_back('{make_query(0, 60, 7, 7), 0, none});
		request_table.push_back('{make_query(0, 31'h7FFF_FFFF, 1, 16'hFFFF), 0, none});
		request_table.push_back('{make_query(31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0), 0, none});
		request_table.push_back('{make_query(35, 35, 0, 0), 0, none});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (request_table[i])
			send_request(request_table[i].req, request_table[i].typed,
				request_table[i].res);
		drain();

		// Fill the table to its limit, then overflow it.
		for (int i = 0; i < 70; i++)
			send_request(make_insert(i * 7 + 100), 1'b0, none);
		send_request(make_query(0, 31'h7FFF_FFFF, 0, 0), 1'b0, none);
		run_random(100);

		write_register(CFG_BIN_SIZE, 13'd8191);
		run_random(90);
		write_register(CFG_SHALLOW, 13'd1);
		write_register(CFG_BIN_SIZE, 13'd0);
		run_random(60);
		write_register(CFG_SHALLOW, 13'd0);
		write_register(CFG_SPARE, 13'h1FFF);
		run_random(60);
		write_register(CFG_BIN_SIZE, 13'($urandom_range(2, 8190)));
		run_random(100);

		repeat (100) @(posedge clk);
		$display("%0d requests, %0d results, %0d table-full results, longest query %0d hits",
			requests_sent, results_seen, full_seen, longest_query);
		if (errors == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
